// ----- hdl/srrt_pkg.sv -----
// Shared types and constants for the SACK receive range tracker.
package srrt_pkg;

    localparam logic [31:0] HALF_SPACE = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_INVALID   = 3'd1,
        ST_OUTSIDE   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    localparam logic [0:0] CFG_BASE_ACK     = 1'b0;
    localparam logic [0:0] CFG_SLOTS_IN_USE = 1'b1;

    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] range_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ack_value;
        logic [31:0] ack_advance;
        logic        block_valid;
        logic [31:0] block_start;
        logic [31:0] block_end;
        logic        last;
    } t_out_item;

    // a before b in serial-number order
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        begin
            d = a - b;
            return d[31];
        end
    endfunction

endpackage

// ----- hdl/srrt_cmp.sv -----
// Shared serial-number compare unit: one subtract per cycle, sign bit gives order.
module srrt_cmp (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_before,
    output logic        o_equal
);
    assign o_before = srrt_pkg::seq_before(i_a, i_b);
    assign o_equal  = (i_a == i_b);
endmodule

// ----- hdl/sack_receive_range_tracker.sv -----
// Top level of the SACK receive range tracker: sequencer, slot memory, result stage.
//
// Usage: pulse i_start with a range on i_in while o_busy is low and no config write is
// made in the same cycle. The block checks the range against the cumulative
// acknowledgement, then walks the stored range list one slot per cycle with a single
// shared serial-number comparator: it finds the insert point, merges overlapping slots,
// compacts or shifts the list one entry a cycle, and absorbs slots that become
// contiguous with the acknowledgement. Then it emits one result per stored block (up to
// SACK_BLOCKS, at least one) on o_out, each marked by o_valid for one cycle; the final
// one carries last. o_busy falls in the cycle that shows the last result.
// The walk over the slot memory, one entry per cycle through the one comparator, and the
// number of results set how long o_busy stays high after the accepting edge. One
// transaction at a time.
// Reset empties the range list, sets the acknowledgement to zero and slots_in_use to
// 16. A write of the base acknowledgement register loads the acknowledgement and
// empties the list.
// The receiver cannot stall; results are never held.
module sack_receive_range_tracker #(
    parameter int RANGE_SLOTS = 16,
    parameter int SACK_BLOCKS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  srrt_pkg::t_in_item   i_in,
    output logic                 o_busy,
    output logic                 o_valid,
    output srrt_pkg::t_out_item  o_out,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    localparam int IW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int CW = $clog2(RANGE_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CLIP, S_ABSORB, S_FIND, S_MERGE, S_DECIDE,
        S_WRITE, S_COMPACT, S_SHIFT, S_EMIT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_ack, r_prev_ack, r_s, r_e, r_ms, r_me;
    logic [4:0]   r_slots_in_use;
    logic [CW-1:0] r_count, r_first, r_last, r_idx, r_k;
    logic [2:0]   r_status;
    logic [31:0]  r_starts [RANGE_SLOTS];
    logic [31:0]  r_ends   [RANGE_SLOTS];

    logic [31:0] cmp_a, cmp_b;
    logic        cmp_before, cmp_equal;

    srrt_cmp u_cmp (.i_a(cmp_a), .i_b(cmp_b), .o_before(cmp_before), .o_equal(cmp_equal));

    logic [IW-1:0] idx_a;
    logic [31:0]   rd_s, rd_e;
    logic [CW-1:0] allowed, n_blocks, removed;

    assign idx_a = r_idx[IW-1:0];
    assign rd_s  = r_starts[idx_a];
    assign rd_e  = r_ends[idx_a];
    assign allowed = (32'(r_slots_in_use) > 32'(RANGE_SLOTS)) ? CW'(RANGE_SLOTS)
                   : CW'(r_slots_in_use);
    assign n_blocks = (32'(r_count) < 32'(SACK_BLOCKS)) ? r_count : CW'(SACK_BLOCKS);
    assign removed  = r_last - r_first - CW'(1);
    assign o_busy   = (r_state != S_IDLE);

    // comparator operand selection per state
    always_comb begin
        cmp_a = r_e;
        cmp_b = r_ack;
        case (r_state)
            S_CHECK:  begin cmp_a = r_e;  cmp_b = r_ack; end
            S_CLIP:   begin cmp_a = r_s;  cmp_b = r_ack; end
            S_ABSORB: begin cmp_a = rd_s; cmp_b = r_ack; end
            S_FIND:   begin cmp_a = rd_e; cmp_b = r_s;   end
            S_MERGE:  begin cmp_a = rd_s; cmp_b = r_me;  end
            default:  begin cmp_a = r_e;  cmp_b = r_ack; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ack          <= '0;
            r_slots_in_use <= 5'd16;
            r_count        <= '0;
            o_valid        <= 1'b0;
        end else begin
            o_valid <= (r_state == S_EMIT);
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        if (i_cfg_index == srrt_pkg::CFG_BASE_ACK) begin
                            r_ack   <= i_cfg_data;
                            r_count <= '0;
                        end else begin
                            r_slots_in_use <= i_cfg_data[4:0];
                        end
                    end else if (i_start) begin
                        r_s        <= i_in.range_start;
                        r_e        <= i_in.range_end;
                        r_prev_ack <= r_ack;
                        r_state    <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_idx <= '0;
                    r_k   <= '0;
                    if (r_s == r_e) begin
                        r_status <= srrt_pkg::ST_INVALID;
                        r_state  <= S_EMIT;
                    end else if ((r_e - r_s) >= srrt_pkg::HALF_SPACE) begin
                        r_status <= srrt_pkg::ST_OUTSIDE;
                        r_state  <= S_EMIT;
                    end else if (cmp_before || cmp_equal) begin
                        r_status <= srrt_pkg::ST_DUPLICATE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    if (cmp_before || cmp_equal) begin
                        // starts at or before ack: advance directly
                        r_status <= srrt_pkg::ST_ACCEPTED;
                        r_ack    <= r_e;
                        r_state  <= S_ABSORB;
                    end else if ((r_s - r_ack) >= srrt_pkg::HALF_SPACE) begin
                        r_status <= srrt_pkg::ST_OUTSIDE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_status <= srrt_pkg::ST_ACCEPTED;
                        r_ms     <= r_s;
                        r_me     <= r_e;
                        r_state  <= S_FIND;
                    end
                end
                S_ABSORB: begin
                    if (r_idx < r_count && (cmp_before || cmp_equal)) begin
                        if (srrt_pkg::seq_before(r_ack, rd_e)) r_ack <= rd_e;
                        r_idx <= r_idx + CW'(1);
                    end else if (r_idx != '0) begin
                        // drop r_idx leading entries by compaction
                        r_first <= '0;
                        r_last  <= r_idx;
                        r_idx   <= '0;
                        r_state <= S_COMPACT;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_FIND: begin
                    if (r_idx < r_count && cmp_before) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_first <= r_idx;
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    if (r_idx < r_count && (cmp_before || cmp_equal)) begin
                        if (srrt_pkg::seq_before(rd_s, r_ms)) r_ms <= rd_s;
                        if (srrt_pkg::seq_before(r_me, rd_e)) r_me <= rd_e;
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_last  <= r_idx;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_first == r_last) begin
                        if (r_count >= allowed) begin
                            r_status <= srrt_pkg::ST_FULL;
                            r_idx    <= '0;
                            r_state  <= S_EMIT;
                        end else begin
                            r_idx   <= r_count;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_starts[r_first[IW-1:0]] <= r_ms;
                    r_ends[r_first[IW-1:0]]   <= r_me;
                    if (removed == '0) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_first <= r_first + CW'(1);
                        r_idx   <= r_last;
                        r_state <= S_COMPACT;
                    end
                end
                S_COMPACT: begin
                    // move entry r_last down to r_first, one per cycle
                    if (r_last < r_count) begin
                        r_starts[r_first[IW-1:0]] <= r_starts[r_last[IW-1:0]];
                        r_ends[r_first[IW-1:0]]   <= r_ends[r_last[IW-1:0]];
                        r_first <= r_first + CW'(1);
                        r_last  <= r_last + CW'(1);
                    end else begin
                        r_count <= r_first;
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_SHIFT: begin
                    if (r_idx > r_first) begin
                        r_starts[r_idx[IW-1:0]] <= r_starts[IW'(r_idx - CW'(1))];
                        r_ends[r_idx[IW-1:0]]   <= r_ends[IW'(r_idx - CW'(1))];
                        r_idx <= r_idx - CW'(1);
                    end else begin
                        r_starts[r_first[IW-1:0]] <= r_ms;
                        r_ends[r_first[IW-1:0]]   <= r_me;
                        r_count <= r_count + CW'(1);
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_out.status          <= r_status;
                    o_out.ack_value       <= r_ack;
                    o_out.ack_advance     <= (r_status == srrt_pkg::ST_ACCEPTED)
                                             ? (r_ack - r_prev_ack) : '0;
                    if (n_blocks == '0) begin
                        o_out.block_valid <= 1'b0;
                        o_out.block_start <= '0;
                        o_out.block_end   <= '0;
                        o_out.last        <= 1'b1;
                        r_state           <= S_IDLE;
                    end else begin
                        o_out.block_valid <= 1'b1;
                        o_out.block_start <= r_starts[r_k[IW-1:0]];
                        o_out.block_end   <= r_ends[r_k[IW-1:0]];
                        o_out.last        <= (r_k + CW'(1) == n_blocks);
                        r_k               <= r_k + CW'(1);
                        if (r_k + CW'(1) == n_blocks) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
